/* hdl/jbt_pkg.sv */
// Types, constants and the per-byte scan function of the JSON byte tokenizer.
package jbt_pkg;

  localparam int OFFSET_W    = 16;
  localparam int VALUE_W     = 32;
  localparam int KIND_W      = 4;
  localparam int MAX_RES     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_L = 8'h6C;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_LITERAL,
    MODE_NPRE,
    MODE_NSTART,
    MODE_ND1,
    MODE_ND2,
    MODE_NESIGN,
    MODE_NEXP
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_COLON     = 4'd0,
    KIND_COMMA     = 4'd1,
    KIND_OBJ_OPEN  = 4'd2,
    KIND_OBJ_CLOSE = 4'd3,
    KIND_ARR_OPEN  = 4'd4,
    KIND_ARR_CLOSE = 4'd5,
    KIND_STRING    = 4'd6,
    KIND_NULL      = 4'd7,
    KIND_TRUE      = 4'd8,
    KIND_FALSE     = 4'd9,
    KIND_FLOAT     = 4'd10,
    KIND_UNSIGNED  = 4'd11,
    KIND_SIGNED    = 4'd12,
    KIND_ERROR     = 4'd13,
    KIND_END       = 4'd14
  } kind_e;

  typedef enum logic [1:0] {
    LIT_NULL  = 2'd0,
    LIT_TRUE  = 2'd1,
    LIT_FALSE = 2'd2
  } lit_e;

  typedef enum logic [1:0] {
    NUM_TAKE,
    NUM_END,
    NUM_ERR
  } num_res_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]   token_kind;
    logic [OFFSET_W-1:0] token_start;
    logic [OFFSET_W-1:0] token_length;
    logic [VALUE_W-1:0]  int_value;
    logic                int_overflow;
    logic                last_result;
  } out_t;

  typedef struct packed {
    logic neg;
    logic frac;
    logic mdig;
    logic edig;
  } num_flags_t;

  typedef struct packed {
    mode_e               mode;
    logic [1:0]          lit_kind;
    logic [2:0]          lit_index;
    logic [OFFSET_W-1:0] byte_pos;
    logic [OFFSET_W-1:0] start_off;
    logic [OFFSET_W-1:0] text_len;
    logic [VALUE_W-1:0]  acc;
    logic                ovf;
    num_flags_t          flags;
  } state_t;

  typedef struct packed {
    state_t   st;
    num_res_e res;
  } num_step_t;

  typedef struct packed {
    state_t st;
    logic   emit;
    out_t   tok;
  } idle_step_t;

  typedef struct packed {
    state_t                    st;
    logic [RES_CNT_W-1:0]      count;
    out_t [MAX_RES-1:0]        toks;
  } step_t;

  function automatic state_t reset_state();
    state_t s;
    s      = '0;
    s.mode = MODE_IDLE;
    return s;
  endfunction

  function automatic state_t go_idle(state_t s);
    state_t r;
    r           = s;
    r.mode      = MODE_IDLE;
    r.lit_kind  = '0;
    r.lit_index = '0;
    r.text_len  = '0;
    r.acc       = '0;
    r.ovf       = 1'b0;
    r.flags     = '0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [OFFSET_W-1:0] sat_inc(logic [OFFSET_W-1:0] v);
    return (v == '1) ? v : v + OFFSET_W'(1);
  endfunction

  function automatic out_t make_tok(logic [KIND_W-1:0] kind, logic [OFFSET_W-1:0] start,
                                    logic [OFFSET_W-1:0] len, logic [VALUE_W-1:0] val,
                                    logic ovf);
    out_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.int_value    = val;
    t.int_overflow = ovf;
    t.last_result  = 1'b0;
    return t;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] lk);
    return (lk == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] lk, logic [2:0] li);
    logic [7:0] c;
    c = 8'h00;
    case (lk)
      LIT_FALSE: begin
        case (li)
          3'd0:    c = CH_LOWER_F;
          3'd1:    c = CH_LOWER_A;
          3'd2:    c = CH_LOWER_L;
          3'd3:    c = CH_LOWER_S;
          3'd4:    c = CH_LOWER_E;
          default: c = 8'h00;
        endcase
      end
      LIT_TRUE: begin
        case (li)
          3'd0:    c = CH_LOWER_T;
          3'd1:    c = CH_LOWER_R;
          3'd2:    c = CH_LOWER_U;
          3'd3:    c = CH_LOWER_E;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (li)
          3'd0:    c = CH_LOWER_N;
          3'd1:    c = CH_LOWER_U;
          3'd2:    c = CH_LOWER_L;
          3'd3:    c = CH_LOWER_L;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  // Advances the number scanner by one byte; modes fall through in order.
  function automatic num_step_t number_byte(state_t s, logic [7:0] c);
    num_step_t        r;
    logic             done;
    logic [VALUE_W+3:0] prod;
    r.st  = s;
    r.res = NUM_TAKE;
    done  = 1'b0;
    prod  = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (VALUE_W + 4)'(c - CH_ZERO);
    if (r.st.mode == MODE_NPRE) begin
      r.st.mode = MODE_NSTART;
      if (c == CH_MINUS) begin
        r.st.flags.neg = 1'b1;
        done           = 1'b1;
      end
    end
    if (!done && r.st.mode == MODE_NSTART) begin
      r.st.mode = MODE_ND1;
      if (c == CH_DOT) begin
        r.st.flags.frac = 1'b1;
        done            = 1'b1;
      end
    end
    if (!done && r.st.mode == MODE_ND1) begin
      if (is_digit(c)) begin
        r.st.flags.mdig = 1'b1;
        if (prod[VALUE_W+3:VALUE_W] != '0) begin
          r.st.ovf = 1'b1;
        end
        r.st.acc = prod[VALUE_W-1:0];
        done     = 1'b1;
      end else begin
        r.st.mode = MODE_ND2;
        if (c == CH_DOT) begin
          r.st.flags.frac = 1'b1;
          done            = 1'b1;
        end
      end
    end
    if (!done && r.st.mode == MODE_ND2) begin
      done = 1'b1;
      if (is_digit(c)) begin
        r.st.flags.mdig = 1'b1;
      end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
        if (!r.st.flags.mdig) begin
          r.res = NUM_ERR;
        end else begin
          r.st.flags.frac = 1'b1;
          r.st.mode       = MODE_NESIGN;
        end
      end else begin
        r.res = NUM_END;
      end
    end
    if (!done && r.st.mode == MODE_NESIGN) begin
      r.st.mode = MODE_NEXP;
      if (c == CH_MINUS) begin
        done = 1'b1;
      end
    end
    if (!done) begin
      if (is_digit(c)) begin
        r.st.flags.edig = 1'b1;
      end else begin
        r.res = NUM_END;
      end
    end
    return r;
  endfunction

  function automatic out_t finish_number(state_t s);
    out_t t;
    if (!s.flags.mdig && !s.flags.edig) begin
      t = make_tok(KIND_ERROR, s.start_off, s.text_len, '0, 1'b0);
    end else if (s.flags.frac) begin
      t = make_tok(KIND_FLOAT, s.start_off, s.text_len, '0, 1'b0);
    end else if (s.flags.neg) begin
      t = make_tok(KIND_SIGNED, s.start_off, s.text_len, s.acc, s.ovf);
    end else begin
      t = make_tok(KIND_UNSIGNED, s.start_off, s.text_len, s.acc, s.ovf);
    end
    return t;
  endfunction

  function automatic idle_step_t idle_byte(state_t s, logic [7:0] c,
                                           logic [OFFSET_W-1:0] pos);
    idle_step_t r;
    num_step_t  nb;
    r.st   = s;
    r.emit = 1'b0;
    r.tok  = make_tok(KIND_ERROR, pos, OFFSET_W'(1), '0, 1'b0);
    nb     = number_byte(go_idle(s), c);
    case (c)
      CH_COLON: begin
        r.emit           = 1'b1;
        r.tok.token_kind = KIND_COLON;
      end
      CH_COMMA: begin
        r.emit           = 1'b1;
        r.tok.token_kind = KIND_COMMA;
      end
      CH_LBRACE: begin
        r.emit           = 1'b1;
        r.tok.token_kind = KIND_OBJ_OPEN;
      end
      CH_RBRACE: begin
        r.emit           = 1'b1;
        r.tok.token_kind = KIND_OBJ_CLOSE;
      end
      CH_LBRACK: begin
        r.emit           = 1'b1;
        r.tok.token_kind = KIND_ARR_OPEN;
      end
      CH_RBRACK: begin
        r.emit           = 1'b1;
        r.tok.token_kind = KIND_ARR_CLOSE;
      end
      default: begin
        if (c == CH_SPACE || c inside {[CH_TAB:CH_CR]}) begin
          r.emit = 1'b0;
        end else if (c == CH_QUOTE) begin
          r.st           = go_idle(s);
          r.st.mode      = MODE_STRING;
          r.st.start_off = pos + OFFSET_W'(1);
        end else if (c == CH_LOWER_N || c == CH_LOWER_T || c == CH_LOWER_F) begin
          r.st           = go_idle(s);
          r.st.mode      = MODE_LITERAL;
          r.st.lit_kind  = (c == CH_LOWER_N) ? LIT_NULL :
                           (c == CH_LOWER_T) ? LIT_TRUE : LIT_FALSE;
          r.st.lit_index = 3'd1;
          r.st.start_off = pos;
          r.st.text_len  = OFFSET_W'(1);
        end else if (c == CH_MINUS || c == CH_DOT || is_digit(c)) begin
          nb             = number_byte('{mode: MODE_NPRE, default: '0}, c);
          r.st           = nb.st;
          r.st.byte_pos  = s.byte_pos;
          r.st.start_off = pos;
          r.st.text_len  = OFFSET_W'(1);
        end else begin
          r.emit = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Full update for one text byte: next state and up to three tokens.
  function automatic step_t step(state_t s, in_t in);
    step_t      r;
    idle_step_t ib;
    num_step_t  nb;
    logic [7:0] c;
    logic [OFFSET_W-1:0] pos;
    logic [2:0] li;
    c       = in.in_byte;
    pos     = s.byte_pos;
    r.st    = s;
    r.count = '0;
    r.toks  = '0;
    li      = s.lit_index;
    ib      = idle_byte(go_idle(s), c, pos);
    nb      = number_byte(s, c);
    case (s.mode)
      MODE_IDLE: begin
        r.st = ib.st;
        if (ib.emit) begin
          r.toks[r.count] = ib.tok;
          r.count         = r.count + RES_CNT_W'(1);
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          r.toks[r.count] = make_tok(KIND_STRING, s.start_off, s.text_len, '0, 1'b0);
          r.count         = r.count + RES_CNT_W'(1);
          r.st            = go_idle(s);
        end else begin
          r.st.text_len = sat_inc(s.text_len);
        end
      end
      MODE_LITERAL: begin
        if (li < lit_len(s.lit_kind) && c == lit_char(s.lit_kind, li)) begin
          r.st.lit_index = li + 3'd1;
          r.st.text_len  = sat_inc(s.text_len);
          if (r.st.lit_index >= lit_len(s.lit_kind)) begin
            r.toks[r.count] = make_tok(KIND_W'(KIND_NULL) + KIND_W'(s.lit_kind),
                                       s.start_off, r.st.text_len, '0, 1'b0);
            r.count         = r.count + RES_CNT_W'(1);
            r.st            = go_idle(r.st);
          end
        end else begin
          r.toks[r.count] = make_tok(KIND_ERROR, s.start_off, sat_inc(s.text_len),
                                     '0, 1'b0);
          r.count         = r.count + RES_CNT_W'(1);
          r.st            = go_idle(s);
        end
      end
      MODE_NPRE, MODE_NSTART, MODE_ND1, MODE_ND2, MODE_NESIGN, MODE_NEXP: begin
        case (nb.res)
          NUM_TAKE: begin
            r.st          = nb.st;
            r.st.text_len = sat_inc(s.text_len);
          end
          NUM_END: begin
            r.toks[r.count] = finish_number(nb.st);
            r.count         = r.count + RES_CNT_W'(1);
            r.st            = ib.st;
            if (ib.emit) begin
              r.toks[r.count] = ib.tok;
              r.count         = r.count + RES_CNT_W'(1);
            end
          end
          default: begin
            r.toks[r.count] = make_tok(KIND_ERROR, s.start_off, sat_inc(s.text_len),
                                       '0, 1'b0);
            r.count         = r.count + RES_CNT_W'(1);
            r.st            = go_idle(s);
          end
        endcase
      end
      default: begin
        r.st = ib.st;
        if (ib.emit) begin
          r.toks[r.count] = ib.tok;
          r.count         = r.count + RES_CNT_W'(1);
        end
      end
    endcase
    r.st.byte_pos = pos + OFFSET_W'(1);
    if (in.end_of_input) begin
      if (r.st.mode == MODE_STRING || r.st.mode == MODE_LITERAL) begin
        r.toks[r.count] = make_tok(KIND_ERROR, r.st.start_off, r.st.text_len, '0, 1'b0);
        r.count         = r.count + RES_CNT_W'(1);
      end else if (r.st.mode inside {[MODE_NPRE:MODE_NEXP]}) begin
        r.toks[r.count] = finish_number(r.st);
        r.count         = r.count + RES_CNT_W'(1);
      end
      r.toks[r.count] = make_tok(KIND_END, r.st.byte_pos, '0, '0, 1'b0);
      r.count         = r.count + RES_CNT_W'(1);
      r.st            = reset_state();
    end
    if (r.count != '0) begin
      r.toks[r.count - RES_CNT_W'(1)].last_result = 1'b1;
    end
    return r;
  endfunction

endpackage

/* hdl/json_byte_tokenizer_top.sv */
// Top level of the JSON byte tokenizer: scan state register and result queue.
//
//   Channel   Dir  Handshake                  Payload
//   in        in   in_valid_i / in_ready_o    in_data_i  (jbt_pkg::in_t)
//   out       out  out_valid_o / out_ready_i  out_data_o (jbt_pkg::out_t)
//
// One text byte is accepted per cycle while in_ready_o is high; its zero to
// three tokens enter a four-entry result queue in that cycle and leave it one
// per cycle while out_ready_i is high, in the order in which they entered.
// The input takes a request whenever the queue holds at most one token, so a
// steady stream of one token per byte runs at full rate.
// When the output stalls, the queue fills and in_ready_o drops.
// Reset returns the scanner to idle at offset zero and empties the queue.
module json_byte_tokenizer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jbt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jbt_pkg::out_t  out_data_o
);

  jbt_pkg::state_t                     state_q;
  jbt_pkg::step_t                      step_res;
  jbt_pkg::out_t                       queue_q [jbt_pkg::QUEUE_DEPTH];
  logic [jbt_pkg::PTR_W-1:0]           wr_ptr_q, wr_ptr_d;
  logic [jbt_pkg::PTR_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [jbt_pkg::CNT_W-1:0]           count_q, count_d;
  logic                                push;
  logic                                pop;
  logic [jbt_pkg::CNT_W-1:0]           push_cnt;

  assign step_res    = jbt_pkg::step(state_q, in_data_i);
  assign in_ready_o  = count_q <= jbt_pkg::CNT_W'(jbt_pkg::QUEUE_DEPTH - jbt_pkg::MAX_RES);
  assign push        = in_valid_i && in_ready_o;
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = queue_q[rd_ptr_q];
  assign push_cnt    = push ? jbt_pkg::CNT_W'(step_res.count) : '0;

  always_comb begin
    wr_ptr_d = wr_ptr_q + jbt_pkg::PTR_W'(push_cnt);
    rd_ptr_d = pop ? rd_ptr_q + jbt_pkg::PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + push_cnt - (pop ? jbt_pkg::CNT_W'(1) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= jbt_pkg::reset_state();
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        state_q <= step_res.st;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < jbt_pkg::MAX_RES; i++) begin
      if (push && jbt_pkg::RES_CNT_W'(i) < step_res.count) begin
        queue_q[wr_ptr_q + jbt_pkg::PTR_W'(i)] <= step_res.toks[i];
      end
    end
  end

endmodule

/* dv/tb_json_byte_tokenizer_top.sv */
`timescale 1ns / 100ps
// Testbench for json_byte_tokenizer_top: directed and random JSON text against a token predictor.
module tb_json_byte_tokenizer_top;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  jbt_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  jbt_pkg::out_t out_data;

  bit   idle_on = 1'b1;
  int   out_hold_cycles = 0;
  int   mismatch_count = 0;

  jbt_pkg::out_t tokens_due[$];
  jbt_pkg::out_t step_toks[$];
  logic [7:0]    text_frag[$];

  jbt_pkg::mode_e               scan_st = jbt_pkg::MODE_IDLE;
  jbt_pkg::lit_e                lit_sel = jbt_pkg::LIT_NULL;
  logic [2:0]                   lit_pos = '0;
  logic [jbt_pkg::OFFSET_W-1:0] cur_pos = '0;
  logic [jbt_pkg::OFFSET_W-1:0] tok_start = '0;
  logic [jbt_pkg::OFFSET_W-1:0] tok_len = '0;
  logic [jbt_pkg::VALUE_W-1:0]  mag = '0;
  logic                         mag_wrapped = 1'b0;
  jbt_pkg::num_flags_t          nflags = '0;

  json_byte_tokenizer_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #4 clk = ~clk;

  function automatic logic is_num(logic [7:0] c);
    return (c >= jbt_pkg::CH_ZERO) && (c <= jbt_pkg::CH_NINE);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == jbt_pkg::CH_SPACE) || (c >= jbt_pkg::CH_TAB && c <= jbt_pkg::CH_CR);
  endfunction

  function automatic logic [jbt_pkg::OFFSET_W-1:0] len_inc(
      logic [jbt_pkg::OFFSET_W-1:0] v);
    return (v == {jbt_pkg::OFFSET_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [2:0] lit_size(jbt_pkg::lit_e sel);
    return (sel == jbt_pkg::LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_letter(jbt_pkg::lit_e sel, logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      jbt_pkg::LIT_TRUE: begin
        case (idx)
          3'd0:    c = jbt_pkg::CH_LOWER_T;
          3'd1:    c = jbt_pkg::CH_LOWER_R;
          3'd2:    c = jbt_pkg::CH_LOWER_U;
          3'd3:    c = jbt_pkg::CH_LOWER_E;
          default: c = 8'h00;
        endcase
      end
      jbt_pkg::LIT_FALSE: begin
        case (idx)
          3'd0:    c = jbt_pkg::CH_LOWER_F;
          3'd1:    c = jbt_pkg::CH_LOWER_A;
          3'd2:    c = jbt_pkg::CH_LOWER_L;
          3'd3:    c = jbt_pkg::CH_LOWER_S;
          3'd4:    c = jbt_pkg::CH_LOWER_E;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    c = jbt_pkg::CH_LOWER_N;
          3'd1:    c = jbt_pkg::CH_LOWER_U;
          3'd2:    c = jbt_pkg::CH_LOWER_L;
          3'd3:    c = jbt_pkg::CH_LOWER_L;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic void push_tok(logic [jbt_pkg::KIND_W-1:0] kind,
                                   logic [jbt_pkg::OFFSET_W-1:0] start,
                                   logic [jbt_pkg::OFFSET_W-1:0] len,
                                   logic [jbt_pkg::VALUE_W-1:0] val,
                                   logic ovf);
    jbt_pkg::out_t t;
    if (step_toks.size() >= jbt_pkg::MAX_RES) return;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.int_value    = val;
    t.int_overflow = ovf;
    t.last_result  = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void clear_scan();
    scan_st     = jbt_pkg::MODE_IDLE;
    lit_sel     = jbt_pkg::LIT_NULL;
    lit_pos     = '0;
    tok_len     = '0;
    mag         = '0;
    mag_wrapped = 1'b0;
    nflags      = '0;
  endfunction

  function automatic jbt_pkg::num_res_e scan_number(logic [7:0] c);
    logic [jbt_pkg::VALUE_W+3:0] wide;
    if (scan_st == jbt_pkg::MODE_NPRE) begin
      scan_st = jbt_pkg::MODE_NSTART;
      if (c == jbt_pkg::CH_MINUS) begin
        nflags.neg = 1'b1;
        return jbt_pkg::NUM_TAKE;
      end
    end
    if (scan_st == jbt_pkg::MODE_NSTART) begin
      scan_st = jbt_pkg::MODE_ND1;
      if (c == jbt_pkg::CH_DOT) begin
        nflags.frac = 1'b1;
        return jbt_pkg::NUM_TAKE;
      end
    end
    if (scan_st == jbt_pkg::MODE_ND1) begin
      if (is_num(c)) begin
        nflags.mdig = 1'b1;
        wide = {4'b0, mag} * (jbt_pkg::VALUE_W + 4)'(10)
               + (jbt_pkg::VALUE_W + 4)'(c - jbt_pkg::CH_ZERO);
        if (wide[jbt_pkg::VALUE_W+3:jbt_pkg::VALUE_W] != '0) mag_wrapped = 1'b1;
        mag = wide[jbt_pkg::VALUE_W-1:0];
        return jbt_pkg::NUM_TAKE;
      end
      scan_st = jbt_pkg::MODE_ND2;
      if (c == jbt_pkg::CH_DOT) begin
        nflags.frac = 1'b1;
        return jbt_pkg::NUM_TAKE;
      end
    end
    if (scan_st == jbt_pkg::MODE_ND2) begin
      if (is_num(c)) begin
        nflags.mdig = 1'b1;
        return jbt_pkg::NUM_TAKE;
      end
      if (c == jbt_pkg::CH_LOWER_E || c == jbt_pkg::CH_UPPER_E) begin
        if (!nflags.mdig) return jbt_pkg::NUM_ERR;
        nflags.frac = 1'b1;
        scan_st     = jbt_pkg::MODE_NESIGN;
        return jbt_pkg::NUM_TAKE;
      end
      return jbt_pkg::NUM_END;
    end
    if (scan_st == jbt_pkg::MODE_NESIGN) begin
      scan_st = jbt_pkg::MODE_NEXP;
      if (c == jbt_pkg::CH_MINUS) return jbt_pkg::NUM_TAKE;
    end
    if (is_num(c)) begin
      nflags.edig = 1'b1;
      return jbt_pkg::NUM_TAKE;
    end
    return jbt_pkg::NUM_END;
  endfunction

  function automatic void close_number();
    if (!nflags.mdig && !nflags.edig) begin
      push_tok(jbt_pkg::KIND_ERROR, tok_start, tok_len, '0, 1'b0);
    end else if (nflags.frac) begin
      push_tok(jbt_pkg::KIND_FLOAT, tok_start, tok_len, '0, 1'b0);
    end else begin
      push_tok(nflags.neg ? jbt_pkg::KIND_SIGNED : jbt_pkg::KIND_UNSIGNED,
               tok_start, tok_len, mag, mag_wrapped);
    end
    clear_scan();
  endfunction

  function automatic void idle_char(logic [7:0] c, logic [jbt_pkg::OFFSET_W-1:0] pos);
    case (c)
      jbt_pkg::CH_COLON:
        push_tok(jbt_pkg::KIND_COLON, pos, jbt_pkg::OFFSET_W'(1), '0, 1'b0);
      jbt_pkg::CH_COMMA:
        push_tok(jbt_pkg::KIND_COMMA, pos, jbt_pkg::OFFSET_W'(1), '0, 1'b0);
      jbt_pkg::CH_LBRACE:
        push_tok(jbt_pkg::KIND_OBJ_OPEN, pos, jbt_pkg::OFFSET_W'(1), '0, 1'b0);
      jbt_pkg::CH_RBRACE:
        push_tok(jbt_pkg::KIND_OBJ_CLOSE, pos, jbt_pkg::OFFSET_W'(1), '0, 1'b0);
      jbt_pkg::CH_LBRACK:
        push_tok(jbt_pkg::KIND_ARR_OPEN, pos, jbt_pkg::OFFSET_W'(1), '0, 1'b0);
      jbt_pkg::CH_RBRACK:
        push_tok(jbt_pkg::KIND_ARR_CLOSE, pos, jbt_pkg::OFFSET_W'(1), '0, 1'b0);
      default: begin
        if (is_blank(c)) begin
          return;
        end else if (c == jbt_pkg::CH_QUOTE) begin
          clear_scan();
          scan_st   = jbt_pkg::MODE_STRING;
          tok_start = pos + 1'b1;
        end else if (c == jbt_pkg::CH_LOWER_N || c == jbt_pkg::CH_LOWER_T ||
                     c == jbt_pkg::CH_LOWER_F) begin
          clear_scan();
          scan_st   = jbt_pkg::MODE_LITERAL;
          lit_sel   = (c == jbt_pkg::CH_LOWER_N) ? jbt_pkg::LIT_NULL :
                      (c == jbt_pkg::CH_LOWER_T) ? jbt_pkg::LIT_TRUE : jbt_pkg::LIT_FALSE;
          lit_pos   = 3'd1;
          tok_start = pos;
          tok_len   = jbt_pkg::OFFSET_W'(1);
        end else if (c == jbt_pkg::CH_MINUS || c == jbt_pkg::CH_DOT || is_num(c)) begin
          clear_scan();
          scan_st   = jbt_pkg::MODE_NPRE;
          tok_start = pos;
          void'(scan_number(c));
          tok_len   = jbt_pkg::OFFSET_W'(1);
        end else begin
          push_tok(jbt_pkg::KIND_ERROR, pos, jbt_pkg::OFFSET_W'(1), '0, 1'b0);
        end
      end
    endcase
  endfunction

  function automatic void predict_tokens(jbt_pkg::in_t d);
    logic [7:0]                   c;
    logic [jbt_pkg::OFFSET_W-1:0] pos;
    c   = d.in_byte;
    pos = cur_pos;
    step_toks.delete();
    case (scan_st)
      jbt_pkg::MODE_IDLE: idle_char(c, pos);
      jbt_pkg::MODE_STRING: begin
        if (c == jbt_pkg::CH_QUOTE) begin
          push_tok(jbt_pkg::KIND_STRING, tok_start, tok_len, '0, 1'b0);
          clear_scan();
        end else begin
          tok_len = len_inc(tok_len);
        end
      end
      jbt_pkg::MODE_LITERAL: begin
        if (lit_pos < lit_size(lit_sel) && c == lit_letter(lit_sel, lit_pos)) begin
          lit_pos = lit_pos + 3'd1;
          tok_len = len_inc(tok_len);
          if (lit_pos >= lit_size(lit_sel)) begin
            push_tok(jbt_pkg::KIND_W'(jbt_pkg::KIND_NULL) + jbt_pkg::KIND_W'(lit_sel),
                     tok_start, tok_len, '0, 1'b0);
            clear_scan();
          end
        end else begin
          push_tok(jbt_pkg::KIND_ERROR, tok_start, len_inc(tok_len), '0, 1'b0);
          clear_scan();
        end
      end
      default: begin
        case (scan_number(c))
          jbt_pkg::NUM_TAKE: tok_len = len_inc(tok_len);
          jbt_pkg::NUM_END: begin
            close_number();
            idle_char(c, pos);
          end
          default: begin
            push_tok(jbt_pkg::KIND_ERROR, tok_start, len_inc(tok_len), '0, 1'b0);
            clear_scan();
          end
        endcase
      end
    endcase
    cur_pos = pos + 1'b1;
    if (d.end_of_input) begin
      if (scan_st == jbt_pkg::MODE_STRING || scan_st == jbt_pkg::MODE_LITERAL) begin
        push_tok(jbt_pkg::KIND_ERROR, tok_start, tok_len, '0, 1'b0);
      end else if (scan_st != jbt_pkg::MODE_IDLE) begin
        close_number();
      end
      push_tok(jbt_pkg::KIND_END, cur_pos, '0, '0, 1'b0);
      clear_scan();
      cur_pos   = '0;
      tok_start = '0;
    end
    if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last_result = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
  endtask

  always @(posedge clk) begin : token_check
    jbt_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("token of kind %0d with none predicted", out_data.token_kind));
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", 32'(out_data.token_kind), 32'(want.token_kind));
        check_field("token_start", 32'(out_data.token_start), 32'(want.token_start));
        check_field("token_length", 32'(out_data.token_length), 32'(want.token_length));
        check_field("int_value", out_data.int_value, want.int_value);
        check_field("int_overflow", 32'(out_data.int_overflow), 32'(want.int_overflow));
        check_field("last_result", 32'(out_data.last_result), 32'(want.last_result));
      end
    end
  end

  initial begin : result_sink
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_hold_cycles != 0) begin
        n               = out_hold_cycles;
        out_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    jbt_pkg::in_t req;
    req.in_byte      = b;
    req.end_of_input = last;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_tokens(req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_text(string s, logic close_text);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], close_text && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_structure();
    send_text("{\"\":[,]}", 1'b1);
  endtask

  task automatic test_literals();
    send_text("falsenx", 1'b0);
  endtask

  task automatic test_numbers();
    send_text("-.e 12]", 1'b1);
  endtask

  task automatic test_bad_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\"a", 1'b1);
  endtask

  task automatic push_digits(int n);
    int i;
    for (i = 0; i < n; i++) text_frag.push_back(8'(jbt_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic test_random_text(int target);
    int    sent;
    int    cut;
    int    i;
    int    n;
    string word;
    sent = 0;
    while (sent < target) begin
      text_frag.delete();
      case ($urandom_range(0, 11))
        0, 1: begin
          case ($urandom_range(0, 5))
            0:       text_frag.push_back(jbt_pkg::CH_COLON);
            1:       text_frag.push_back(jbt_pkg::CH_COMMA);
            2:       text_frag.push_back(jbt_pkg::CH_LBRACE);
            3:       text_frag.push_back(jbt_pkg::CH_RBRACE);
            4:       text_frag.push_back(jbt_pkg::CH_LBRACK);
            default: text_frag.push_back(jbt_pkg::CH_RBRACK);
          endcase
        end
        2: text_frag.push_back(($urandom_range(0, 1) == 0) ? jbt_pkg::CH_SPACE :
                               8'($urandom_range(jbt_pkg::CH_TAB, jbt_pkg::CH_CR)));
        3, 4: begin
          text_frag.push_back(jbt_pkg::CH_QUOTE);
          n = $urandom_range(0, 6);
          for (i = 0; i < n; i++) begin
            text_frag.push_back(8'($urandom_range(0, 255)));
            if (text_frag[i + 1] == jbt_pkg::CH_QUOTE) text_frag[i + 1] = 8'h00;
          end
          text_frag.push_back(jbt_pkg::CH_QUOTE);
        end
        5, 6, 7: begin
          if ($urandom_range(0, 1) == 0) text_frag.push_back(jbt_pkg::CH_MINUS);
          if ($urandom_range(0, 9) == 0) begin
            text_frag.push_back(jbt_pkg::CH_DOT);
            push_digits($urandom_range(1, 3));
          end else begin
            push_digits(($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) :
                        $urandom_range(1, 4));
            if ($urandom_range(0, 9) < 3) begin
              text_frag.push_back(jbt_pkg::CH_DOT);
              push_digits($urandom_range(1, 3));
            end
          end
          if ($urandom_range(0, 3) == 0) begin
            text_frag.push_back(($urandom_range(0, 1) == 0) ? jbt_pkg::CH_LOWER_E :
                                jbt_pkg::CH_UPPER_E);
            if ($urandom_range(0, 1) == 0) text_frag.push_back(jbt_pkg::CH_MINUS);
            push_digits($urandom_range(1, 2));
          end
          if ($urandom_range(0, 1) == 0) text_frag.push_back(jbt_pkg::CH_COMMA);
        end
        8, 9: begin
          case ($urandom_range(0, 2))
            0:       word = "null";
            1:       word = "true";
            default: word = "false";
          endcase
          n = (text_frag.size() == 0 && $urandom_range(0, 2) == 0) ?
              $urandom_range(1, word.len() - 1) : word.len();
          for (i = 0; i < n; i++) text_frag.push_back(word[i]);
          if (n < word.len()) text_frag.push_back(8'($urandom_range(0, 255)));
        end
        10: begin
          case ($urandom_range(0, 3))
            0: text_frag.push_back(($urandom_range(0, 1) == 0) ? jbt_pkg::CH_MINUS :
                                   jbt_pkg::CH_DOT);
            1: begin
              if ($urandom_range(0, 1) == 0) text_frag.push_back(jbt_pkg::CH_MINUS);
              if ($urandom_range(0, 1) == 0) text_frag.push_back(jbt_pkg::CH_DOT);
              text_frag.push_back(($urandom_range(0, 1) == 0) ? jbt_pkg::CH_LOWER_E :
                                  jbt_pkg::CH_UPPER_E);
            end
            2: begin
              push_digits($urandom_range(1, 2));
              text_frag.push_back(jbt_pkg::CH_DOT);
              push_digits($urandom_range(0, 2));
              text_frag.push_back(jbt_pkg::CH_DOT);
              push_digits($urandom_range(0, 2));
            end
            default: begin
              push_digits($urandom_range(1, 3));
              text_frag.push_back(jbt_pkg::CH_LOWER_E);
              if ($urandom_range(0, 1) == 0) text_frag.push_back(jbt_pkg::CH_MINUS);
              text_frag.push_back(8'($urandom_range(0, 255)));
            end
          endcase
        end
        default: text_frag.push_back(8'($urandom_range(0, 255)));
      endcase
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, text_frag.size() - 1) :
            text_frag.size();
      for (i = 0; i < text_frag.size() && i <= cut; i++) begin
        send_byte(text_frag[i], i == cut);
        if (!is_blank(text_frag[i]) || i == cut) sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    bit idle_saved;
    int i;
    wait_drained();
    idle_saved      = idle_on;
    idle_on         = 1'b0;
    out_hold_cycles = 80;
    for (i = 0; i < 16; i++) send_byte(i[0] ? jbt_pkg::CH_COMMA : jbt_pkg::CH_COLON, 1'b0);
    wait_drained();
    idle_on = idle_saved;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_structure();
    test_literals();
    test_numbers();
    test_bad_bytes();
    test_random_text(115);
    test_backpressure();
    idle_on = 1'b0;
    test_random_text(50);
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
